@@ rtl/switch_topic_parser_macros.svh @@
// ----------------------------------------------------------------------------
// switch_topic_parser assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SWITCH_TOPIC_PARSER_MACROS_SVH
`define SWITCH_TOPIC_PARSER_MACROS_SVH

// same-cycle implication
`define STP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/stp_pkg.sv @@
// ----------------------------------------------------------------------------
// stp_pkg
// Types and constants shared by the switch topic parser modules.
// ----------------------------------------------------------------------------
package stp_pkg;

	localparam int CODE_LEN_DEF = 5;
	localparam int Q_DEPTH      = 2;

	localparam logic [1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [1:0] KIND_DIP     = 2'd1;
	localparam logic [1:0] KIND_CODEID  = 2'd2;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               ok;
		logic signed [31:0] code_id;
		logic [39:0]        code_first;
		logic [39:0]        code_second;
	} out_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        ok;
		logic        sign;
		logic [31:0] mag;
		logic [39:0] code_first;
		logic [39:0] code_second;
	} summary_t;

endpackage

@@ rtl/switch_topic_parser.sv @@
// The summary is queued at the edge that takes the last byte, then registered in the output register.
// Throughput: one byte per cycle while topic_stall is low; the front scanner updates all matchers in one step.
// topic_stall rises only when the summary queue is full behind a held result.
// Reset: asynchronous, clears scanner state, queue pointers and result valid.
// No clearing pass after reset; bytes are taken on the first cycle out of reset.
// ----------------------------------------------------------------------------
// switch_topic_parser
// Classifies a slash-separated topic byte stream and extracts switch codes.
// ----------------------------------------------------------------------------
module switch_topic_parser #(
	parameter int CODE_LEN = stp_pkg::CODE_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          topic_valid,
	output logic          topic_stall,
	input  stp_pkg::in_t  topic,
	output logic          result_valid,
	input  logic          result_stall,
	output stp_pkg::out_t result
);

	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	stp_pkg::summary_t sum;
	stp_pkg::summary_t q_data;

	stp_front #(
		.CODE_LEN(CODE_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.topic_valid (topic_valid),
		.topic_stall (topic_stall),
		.topic       (topic),
		.q_full      (q_full),
		.push        (push),
		.sum         (sum)
	);

	stp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (sum),
		.pop    (pop),
		.rdata  (q_data),
		.full   (q_full),
		.empty  (q_empty)
	);

	stp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ rtl/stp_front.sv @@
// ----------------------------------------------------------------------------
// stp_front
// Byte-wise topic scanner: substring matchers, tokenizer, word checks,
// number accumulator and colon splitter. Emits one summary per topic.
// ----------------------------------------------------------------------------
module stp_front #(
	parameter int CODE_LEN = stp_pkg::CODE_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              topic_valid,
	output logic              topic_stall,
	input  stp_pkg::in_t      topic,
	input  logic              q_full,
	output logic              push,
	output stp_pkg::summary_t sum
);

	localparam int PLW = $clog2(CODE_LEN + 2);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_D0    = 8'h30;
	localparam logic [7:0] CH_D9    = 8'h39;

	localparam logic [2:0] TOK_KIND   = 3'd3;
	localparam logic [2:0] TOK_CODE   = 3'd4;
	localparam logic [2:0] TOK_SWITCH = 3'd5;
	localparam logic [2:0] SAT3       = 3'd7;

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_DIGIT = 2'd1;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam logic [32:0] MAG_MAX = 33'h0_8000_0000;

	function automatic logic [7:0] dip_pat(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = "/";
			3'd1: c = "d";
			3'd2: c = "i";
			3'd3: c = "p";
			3'd4: c = "/";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] codeid_pat(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0: c = "/";
			4'd1: c = "c";
			4'd2: c = "o";
			4'd3: c = "d";
			4'd4: c = "e";
			4'd5: c = "i";
			4'd6: c = "d";
			4'd7: c = "/";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] dip_word(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = "d";
			3'd1: c = "i";
			3'd2: c = "p";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] codeid_word(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = "c";
			3'd1: c = "o";
			3'd2: c = "d";
			3'd3: c = "e";
			3'd4: c = "i";
			3'd5: c = "d";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] switch_word(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = "s";
			3'd1: c = "w";
			3'd2: c = "i";
			3'd3: c = "t";
			3'd4: c = "c";
			3'd5: c = "h";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	logic [2:0]     dip_pos_q,   dip_pos_d;
	logic [3:0]     cid_pos_q,   cid_pos_d;
	logic [1:0]     found_q,     found_d;
	logic [2:0]     tok_idx_q,   tok_idx_d;
	logic           in_tok_q,    in_tok_d;
	logic [2:0]     wflags_q,    wflags_d;
	logic [2:0]     cit_q,       cit_d;
	logic [1:0]     ph_q,        ph_d;
	logic           sign_q,      sign_d;
	logic [31:0]    mag_q,       mag_d;
	logic [1:0]     part_idx_q,  part_idx_d;
	logic [PLW-1:0] part_len_q,  part_len_d;
	logic [39:0]    code1_q,     code1_d;
	logic [39:0]    code2_q,     code2_d;
	logic [1:0]     lens_ok_q,   lens_ok_d;
	logic           ended_q,     ended_d;

	logic        accept;
	logic        active;
	logic        close_req;
	logic        part_close;
	logic        num_skip;
	logic        is_digit;
	logic [35:0] acc;
	logic [1:0]  kind;
	logic        enough;

	assign topic_stall = q_full;
	assign accept      = topic_valid && !topic_stall;
	assign active      = accept && !ended_q && (topic.ch != CH_NUL);
	assign is_digit    = (topic.ch >= CH_D0) && (topic.ch <= CH_D9);

	always_comb begin
		dip_pos_d  = dip_pos_q;
		cid_pos_d  = cid_pos_q;
		found_d    = found_q;
		tok_idx_d  = tok_idx_q;
		in_tok_d   = in_tok_q;
		wflags_d   = wflags_q;
		cit_d      = cit_q;
		ph_d       = ph_q;
		sign_d     = sign_q;
		mag_d      = mag_q;
		part_idx_d = part_idx_q;
		part_len_d = part_len_q;
		code1_d    = code1_q;
		code2_d    = code2_q;
		lens_ok_d  = lens_ok_q;
		ended_d    = ended_q;
		part_close = 1'b0;
		num_skip   = 1'b0;
		acc        = '0;

		if (accept && !ended_q && topic.ch == CH_NUL)
			ended_d = 1'b1;

		if (active) begin
			// substring matchers; a closing slash reopens a match
			if (topic.ch == dip_pat(dip_pos_q))
				dip_pos_d = dip_pos_q + 3'd1;
			else
				dip_pos_d = (topic.ch == CH_SLASH) ? 3'd1 : 3'd0;
			if (dip_pos_d == 3'd5) begin
				found_d[0] = 1'b1;
				dip_pos_d  = 3'd1;
			end
			if (topic.ch == codeid_pat(cid_pos_q))
				cid_pos_d = cid_pos_q + 4'd1;
			else
				cid_pos_d = (topic.ch == CH_SLASH) ? 4'd1 : 4'd0;
			if (cid_pos_d == 4'd8) begin
				found_d[1] = 1'b1;
				cid_pos_d  = 4'd1;
			end

			if (topic.ch != CH_SLASH) begin
				if (!in_tok_q) begin
					in_tok_d = 1'b1;
					if (tok_idx_q != SAT3)
						tok_idx_d = tok_idx_q + 3'd1;
					cit_d = 3'd0;
				end
				case (tok_idx_d)
					TOK_KIND: begin
						if (topic.ch != dip_word(cit_d))
							wflags_d[0] = 1'b0;
						if (topic.ch != codeid_word(cit_d))
							wflags_d[1] = 1'b0;
					end
					TOK_CODE: begin
						if (ph_q == PH_START) begin
							if (topic.ch == CH_SPACE ||
								(topic.ch >= CH_TAB && topic.ch <= CH_CR)) begin
								num_skip = 1'b1;
							end else if (topic.ch == CH_PLUS || topic.ch == CH_MINUS) begin
								sign_d   = (topic.ch == CH_MINUS);
								ph_d     = PH_DIGIT;
								num_skip = 1'b1;
							end else begin
								ph_d = is_digit ? PH_DIGIT : PH_DONE;
							end
						end else if (ph_q == PH_DIGIT && !is_digit) begin
							ph_d = PH_DONE;
						end
						if (!num_skip && ph_d == PH_DIGIT && is_digit) begin
							acc = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0}
								+ {28'd0, topic.ch - CH_D0};
							if (acc > {3'b000, MAG_MAX})
								mag_d = MAG_MAX[31:0];
							else
								mag_d = acc[31:0];
						end

						if (topic.ch == CH_COLON) begin
							part_close = 1'b1;
						end else begin
							if (part_len_q < PLW'(CODE_LEN)) begin
								if (part_idx_q == 2'd0)
									code1_d = {code1_q[31:0], topic.ch};
								else if (part_idx_q == 2'd1)
									code2_d = {code2_q[31:0], topic.ch};
							end
							if (part_len_q < PLW'(CODE_LEN + 1))
								part_len_d = part_len_q + PLW'(1);
						end
					end
					TOK_SWITCH: begin
						if (topic.ch != switch_word(cit_d))
							wflags_d[2] = 1'b0;
					end
					default: begin
					end
				endcase
				if (cit_d != SAT3)
					cit_d = cit_d + 3'd1;
			end
		end

		// token close on slash or at end of topic
		close_req = (active && topic.ch == CH_SLASH) || (accept && topic.last);
		if (close_req && in_tok_d) begin
			case (tok_idx_d)
				TOK_KIND: begin
					if (cit_d != 3'd3)
						wflags_d[0] = 1'b0;
					if (cit_d != 3'd6)
						wflags_d[1] = 1'b0;
				end
				TOK_CODE: part_close = 1'b1;
				TOK_SWITCH: begin
					if (cit_d != 3'd6)
						wflags_d[2] = 1'b0;
				end
				default: begin
				end
			endcase
			in_tok_d = 1'b0;
		end

		if (part_close && part_len_d != '0) begin
			if (part_idx_d < 2'd2 && part_len_d == PLW'(CODE_LEN))
				lens_ok_d[part_idx_d[0]] = 1'b1;
			if (part_idx_d != 2'd3)
				part_idx_d = part_idx_d + 2'd1;
			part_len_d = '0;
		end
	end

	assign push   = accept && topic.last;
	assign enough = tok_idx_d >= TOK_SWITCH;
	assign kind   = found_d[0] ? stp_pkg::KIND_DIP :
		(found_d[1] ? stp_pkg::KIND_CODEID : stp_pkg::KIND_UNKNOWN);

	always_comb begin
		sum.kind        = kind;
		sum.ok          = (kind == stp_pkg::KIND_DIP && enough && wflags_d[2] &&
			wflags_d[0] && lens_ok_d == 2'b11) ||
			(kind == stp_pkg::KIND_CODEID && enough && wflags_d[2] && wflags_d[1]);
		sum.sign        = sign_d;
		sum.mag         = mag_d;
		sum.code_first  = code1_d;
		sum.code_second = code2_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dip_pos_q  <= '0;
			cid_pos_q  <= '0;
			found_q    <= '0;
			tok_idx_q  <= '0;
			in_tok_q   <= 1'b0;
			wflags_q   <= '1;
			cit_q      <= '0;
			ph_q       <= PH_START;
			sign_q     <= 1'b0;
			mag_q      <= '0;
			part_idx_q <= '0;
			part_len_q <= '0;
			code1_q    <= '0;
			code2_q    <= '0;
			lens_ok_q  <= '0;
			ended_q    <= 1'b0;
		end else if (push) begin
			dip_pos_q  <= '0;
			cid_pos_q  <= '0;
			found_q    <= '0;
			tok_idx_q  <= '0;
			in_tok_q   <= 1'b0;
			wflags_q   <= '1;
			cit_q      <= '0;
			ph_q       <= PH_START;
			sign_q     <= 1'b0;
			mag_q      <= '0;
			part_idx_q <= '0;
			part_len_q <= '0;
			code1_q    <= '0;
			code2_q    <= '0;
			lens_ok_q  <= '0;
			ended_q    <= 1'b0;
		end else begin
			dip_pos_q  <= dip_pos_d;
			cid_pos_q  <= cid_pos_d;
			found_q    <= found_d;
			tok_idx_q  <= tok_idx_d;
			in_tok_q   <= in_tok_d;
			wflags_q   <= wflags_d;
			cit_q      <= cit_d;
			ph_q       <= ph_d;
			sign_q     <= sign_d;
			mag_q      <= mag_d;
			part_idx_q <= part_idx_d;
			part_len_q <= part_len_d;
			code1_q    <= code1_d;
			code2_q    <= code2_d;
			lens_ok_q  <= lens_ok_d;
			ended_q    <= ended_d;
		end
	end

endmodule

@@ rtl/stp_queue.sv @@
// ----------------------------------------------------------------------------
// stp_queue
// Short register FIFO of topic summaries between front and back.
// ----------------------------------------------------------------------------
`include "switch_topic_parser_macros.svh"

module stp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  stp_pkg::summary_t wdata,
	input  logic              pop,
	output stp_pkg::summary_t rdata,
	output logic              full,
	output logic              empty
);

	localparam int PW = (stp_pkg::Q_DEPTH > 1) ? $clog2(stp_pkg::Q_DEPTH) : 1;
	localparam int CW = $clog2(stp_pkg::Q_DEPTH + 1);

	stp_pkg::summary_t mem_q [stp_pkg::Q_DEPTH];
	logic [PW-1:0]     wptr_q;
	logic [PW-1:0]     rptr_q;
	logic [CW-1:0]     cnt_q;

	assign full  = (cnt_q == CW'(stp_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PW'(stp_pkg::Q_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			if (pop)
				rptr_q <= (rptr_q == PW'(stp_pkg::Q_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	`STP_ASSERT_NOW(a_no_push_full, full, !push, "summary pushed into full queue")
	`STP_ASSERT_NOW(a_no_pop_empty, pop, !empty, "summary popped from empty queue")
	`STP_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + CW'(1), "count lost a push")
	`STP_ASSERT_NEXT(a_ptr_gap, pop && !push, cnt_q == $past(cnt_q) - CW'(1), "count lost a pop")

endmodule

@@ rtl/stp_back.sv @@
// ----------------------------------------------------------------------------
// stp_back
// Turns a topic summary into the result item: number clamp, field gating,
// output register.
// ----------------------------------------------------------------------------
module stp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  stp_pkg::summary_t q_data,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output stp_pkg::out_t     result
);

	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

	logic          valid_q;
	stp_pkg::out_t result_q;
	stp_pkg::out_t res_d;
	logic          is_cid;
	logic          is_dip;

	assign pop    = !q_empty && (!valid_q || !result_stall);
	assign is_cid = q_data.ok && q_data.kind == stp_pkg::KIND_CODEID;
	assign is_dip = q_data.ok && q_data.kind == stp_pkg::KIND_DIP;

	always_comb begin
		res_d.kind = q_data.kind;
		res_d.ok   = q_data.ok;
		if (!is_cid)
			res_d.code_id = '0;
		else if (q_data.sign)
			res_d.code_id = 32'sd0 - $signed(q_data.mag);
		else
			res_d.code_id = $signed(q_data.mag[31] ? POS_MAX : q_data.mag);
		res_d.code_first  = is_dip ? q_data.code_first : '0;
		res_d.code_second = is_dip ? q_data.code_second : '0;
	end

	always_ff @(posedge clk) begin
		if (pop)
			result_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (!result_stall)
			valid_q <= 1'b0;
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule
